// File: rtl/iap_pkg.sv
// Shared types and helpers for the interpolating allpass filter.
// Holds the sequencer state type, sample widths and the saturation helper.
`timescale 1ns / 1ps
package iap_pkg;

    localparam int SAMPLE_W = 24;
    localparam int GAIN_W   = 16;
    localparam int DELAY_W  = 21;
    localparam int MUL_A_W  = 25;
    localparam int MUL_B_W  = 17;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;

    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd3277;
    localparam logic [DELAY_W-1:0] DELAY_RESET = 21'd0;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ADDR,
        S_RD1,
        S_RD2,
        S_MUL1,
        S_INTERP,
        S_MUL2,
        S_STORE,
        S_MUL3,
        S_OUT
    } t_state;

    typedef enum logic {
        REG_GAIN  = 1'b0,
        REG_DELAY = 1'b1
    } t_reg_idx;

    // Clamp a 28-bit signed value to the 24-bit sample range.
    function automatic logic [SAMPLE_W-1:0] sat24(input logic signed [27:0] v);
        logic [SAMPLE_W-1:0] r;
        if (v > 28'sd8388607) begin
            r = 24'h7FFFFF;
        end else if (v < -28'sd8388608) begin
            r = 24'h800000;
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/iap_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the delay line store.
`timescale 1ns / 1ps
module iap_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/interpolating_allpass_filter.sv
// Top level of the interpolating allpass filter: APB registers, sequencer,
// shared multiplier and delay line. Depends on iap_pkg and iap_ram.
`timescale 1ns / 1ps
//
// Schroeder allpass section over a fractional-length circular delay line.
// Input channel: i_valid / o_ready with i_sample_in (signed Q1.23).
// Output channel: o_valid / i_ready with o_sample_out (signed Q1.23).
// Registers over APB: feedback_gain at 0x0 (Q1.15), delay_length at 0x4
// (samples with 8 fraction bits, clamped to DEPTH*256). Write only while idle.
// Each item walks a ten-state sequencer: address calculation, two reads of
// the delay RAM (one read port), then three products through one shared
// 25x17 multiplier, each followed by a rounding/saturation step.
// o_valid rises as the item leaves S_OUT; the next item is accepted only
// after the sequencer has returned to S_IDLE.
// After reset the delay RAM is cleared one entry per cycle, all DEPTH entries,
// and o_ready stays low until that is done; registers are writable anyway.
// When the receiver stalls, the finished sample holds in the output register;
// the next item may be accepted and processed, then waits in its last state
// until the output register is free.
//
module interpolating_allpass_filter
    import iap_pkg::*;
#(
    parameter int DEPTH = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // input channel
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [SAMPLE_W-1:0] i_sample_in,
    // output channel
    output logic                o_valid,
    input  logic                i_ready,
    output logic [SAMPLE_W-1:0] o_sample_out
);

    localparam int AW   = $clog2(DEPTH);
    localparam int SPAN = DEPTH * 256;
    localparam int DW   = AW + 9;
    localparam int PW   = AW + 10;
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    t_state r_state, n_state;

    logic [GAIN_W-1:0]   r_gain;
    logic [DELAY_W-1:0]  r_delay;
    logic [AW-1:0]       r_clr;
    logic [AW-1:0]       r_wp;
    logic [AW-1:0]       r_i1, r_i2;
    logic [7:0]          r_frac;
    logic [SAMPLE_W-1:0] r_x, r_s1, r_d, r_st, r_out;
    logic signed [PROD_W-1:0] r_prod;
    logic                r_ovalid;

    // ram ports
    logic                ram_we;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [SAMPLE_W-1:0] ram_wdata, ram_rdata;

    // shared multiplier
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;

    logic                      cfg_wr;
    logic                      out_free;
    logic                      accept;
    logic [DW-1:0]             dl_sat;
    logic signed [PW-1:0]      pos_raw;
    logic [PW-1:0]             pos_fix;
    logic [AW-1:0]             i1_c, i2_c;
    logic signed [PROD_W-1:0]  interp_sum;
    logic signed [26:0]        round_p;
    logic [SAMPLE_W-1:0]       stored_c, y_c;

    iap_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (t_reg_idx'(paddr[2]))
            REG_GAIN:  prdata = {16'd0, r_gain};
            REG_DELAY: prdata = {11'd0, r_delay};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= GAIN_RESET;
            r_delay <= DELAY_RESET;
        end else if (cfg_wr) begin
            unique case (t_reg_idx'(paddr[2]))
                REG_GAIN:  r_gain  <= pwdata[GAIN_W-1:0];
                REG_DELAY: r_delay <= pwdata[DELAY_W-1:0];
            endcase
        end
    end

    // ---------------- datapath helpers ----------------
    assign out_free = !r_ovalid || i_ready;
    assign accept   = i_valid && o_ready;

    always_comb begin
        if ({11'd0, r_delay} > 32'(SPAN)) begin
            dl_sat = DW'(SPAN);
        end else begin
            dl_sat = DW'(r_delay);
        end
        pos_raw = $signed({2'b00, r_wp, 8'h00}) - $signed({1'b0, dl_sat});
        // wrap a negative read position back into the store
        if (pos_raw[PW-1]) begin
            pos_fix = PW'(pos_raw) + PW'(SPAN);
        end else begin
            pos_fix = PW'(pos_raw);
        end
        i1_c = pos_fix[AW+7:8];
        i2_c = (i1_c == LAST) ? '0 : i1_c + 1'b1;
    end

    assign mul_p = mul_a * mul_b;

    // s1*256 + (s2-s1)*frac, rounded; the result always fits 24 bits
    assign interp_sum = (PROD_W'($signed(r_s1)) <<< 8) + r_prod + PROD_W'(128);

    assign round_p  = 27'((r_prod + PROD_W'(16384)) >>> 15);
    assign stored_c = sat24(28'(round_p) + 28'($signed(r_x)));
    assign y_c      = sat24(28'($signed(r_d)) - 28'(round_p));

    // ---------------- sequencer: next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (r_clr == LAST) n_state = S_IDLE;
            S_IDLE:   if (i_valid) n_state = S_ADDR;
            S_ADDR:   n_state = S_RD1;
            S_RD1:    n_state = S_RD2;
            S_RD2:    n_state = S_MUL1;
            S_MUL1:   n_state = S_INTERP;
            S_INTERP: n_state = S_MUL2;
            S_MUL2:   n_state = S_STORE;
            S_STORE:  n_state = S_MUL3;
            S_MUL3:   n_state = S_OUT;
            S_OUT:    if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    always_comb begin
        o_ready   = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_wp;
        ram_wdata = stored_c;
        ram_raddr = r_i1;
        mul_a     = $signed(MUL_A_W'($signed(r_d)));
        mul_b     = $signed(MUL_B_W'($signed(r_gain)));
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
            end
            S_IDLE:  o_ready = 1'b1;
            S_RD1:   ram_raddr = r_i1;
            S_RD2:   ram_raddr = r_i2;
            S_MUL1: begin
                mul_a = $signed(MUL_A_W'($signed(ram_rdata))) -
                        $signed(MUL_A_W'($signed(r_s1)));
                mul_b = $signed({9'd0, r_frac});
            end
            S_MUL2:  mul_a = $signed(MUL_A_W'($signed(r_d)));
            S_STORE: ram_we = 1'b1;
            S_MUL3:  mul_a = $signed(MUL_A_W'($signed(r_st)));
            default: ;
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_wp     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            // advance the write position as the item comes in
            if (accept) begin
                r_wp <= (r_wp == LAST) ? '0 : r_wp + 1'b1;
            end
            if (r_state == S_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x <= i_sample_in;
        end
        if (r_state == S_ADDR) begin
            r_i1   <= i1_c;
            r_i2   <= i2_c;
            r_frac <= pos_fix[7:0];
        end
        if (r_state == S_RD2) begin
            r_s1 <= ram_rdata;
        end
        if (r_state == S_MUL1 || r_state == S_MUL2 || r_state == S_MUL3) begin
            r_prod <= mul_p;
        end
        if (r_state == S_INTERP) begin
            r_d <= interp_sum[31:8];
        end
        if (r_state == S_STORE) begin
            r_st <= stored_c;
        end
        if (r_state == S_OUT && out_free) begin
            r_out <= y_c;
        end
    end

    assign o_valid      = r_ovalid;
    assign o_sample_out = r_out;

endmodule
